// ===== rtl/dbcd_pkg.sv =====
// shared types, register indexes and constants for the deadband change detector
`default_nettype none
package dbcd_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned CHANGE_W  = 33;
    localparam int unsigned HEALTH_W  = 17;
    localparam int unsigned DBAND_W   = 31;
    localparam int unsigned SEV_W     = 8;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned QUO_W     = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_EN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DBAND    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEVERITY = 3'd5;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MEAS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HEALTH = 2'd2;

    // health index scale: 1.0 and 0.5 in units of 1/65536
    localparam logic [HEALTH_W-1:0] HEALTH_FULL = 17'd65536;
    localparam logic [HEALTH_W-1:0] HEALTH_HALF = 17'd32768;

    typedef struct packed {
        logic                     high_en;
        logic signed [DATA_W-1:0] high_lim;
        logic                     low_en;
        logic signed [DATA_W-1:0] low_lim;
        logic [DBAND_W-1:0]       dband;
        logic [SEV_W-1:0]         severity;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/dbcd_cfg.sv =====
// configuration register bank of the deadband change detector
`default_nettype none
module dbcd_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dbcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dbcd_pkg::DATA_W-1:0]     cfg_wr_data,
    output dbcd_pkg::cfg_t                       cfg
);

    dbcd_pkg::cfg_t cfg_reg;
    dbcd_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                dbcd_pkg::REG_HIGH_EN:  cfg_next.high_en  = cfg_wr_data[0];
                dbcd_pkg::REG_HIGH_LIM: cfg_next.high_lim = $signed(cfg_wr_data);
                dbcd_pkg::REG_LOW_EN:   cfg_next.low_en   = cfg_wr_data[0];
                dbcd_pkg::REG_LOW_LIM:  cfg_next.low_lim  = $signed(cfg_wr_data);
                dbcd_pkg::REG_DBAND:    cfg_next.dband    = cfg_wr_data[dbcd_pkg::DBAND_W-1:0];
                dbcd_pkg::REG_SEVERITY: cfg_next.severity = cfg_wr_data[dbcd_pkg::SEV_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/dbcd_div.sv =====
// serial restoring divider that turns overshoot and limit into the health index
`default_nettype none
module dbcd_div (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic [dbcd_pkg::DATA_W-1:0]         past,
    input  wire logic signed [dbcd_pkg::DATA_W-1:0]  limit,
    output logic                                     done,
    output logic [dbcd_pkg::HEALTH_W-1:0]            health
);

    localparam int unsigned CNT_W = $clog2(dbcd_pkg::QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(dbcd_pkg::QUO_W - 1);

    logic                              busy_reg, busy_next;
    logic                              first_reg, first_next;
    logic                              done_reg, done_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [dbcd_pkg::DATA_W:0]         rem_reg, rem_next;
    logic [dbcd_pkg::QUO_W-1:0]        quo_reg, quo_next;
    logic [dbcd_pkg::DATA_W-1:0]       mag_reg, mag_next;
    logic                              zero_reg, zero_next;
    logic [dbcd_pkg::HEALTH_W-1:0]     health_reg, health_next;

    logic [dbcd_pkg::DATA_W:0]         cand;
    logic [dbcd_pkg::DATA_W+1:0]       sub;
    logic                              ge;
    logic [dbcd_pkg::QUO_W-1:0]        quo_fin;

    // the one shared subtractor: trial subtract of the magnitude
    always_comb begin
        cand    = first_reg ? rem_reg : {rem_reg[dbcd_pkg::DATA_W-1:0], 1'b0};
        sub     = {1'b0, cand} - {2'b00, mag_reg};
        ge      = !sub[dbcd_pkg::DATA_W+1];
        quo_fin = {quo_reg[dbcd_pkg::QUO_W-2:0], ge};
    end

    always_comb begin
        busy_next   = busy_reg;
        first_next  = first_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        mag_next    = mag_reg;
        zero_next   = zero_reg;
        health_next = health_reg;
        if (start) begin
            busy_next  = 1'b1;
            first_next = 1'b1;
            cnt_next   = '0;
            rem_next   = {1'b0, past};
            quo_next   = '0;
            mag_next   = limit[dbcd_pkg::DATA_W-1] ? (~limit + 1'b1) : limit;
            zero_next  = (limit == '0);
        end else if (busy_reg) begin
            if (first_reg) begin
                // overshoot at least the limit (or zero limit): no divide needed
                first_next = 1'b0;
                if (ge) begin
                    busy_next   = 1'b0;
                    done_next   = 1'b1;
                    health_next = zero_reg ? dbcd_pkg::HEALTH_HALF : '0;
                end
            end else begin
                rem_next = ge ? sub[dbcd_pkg::DATA_W:0] : cand;
                quo_next = quo_fin;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    if (quo_fin[dbcd_pkg::QUO_W-1]) begin
                        health_next = '0;
                    end else begin
                        health_next = dbcd_pkg::HEALTH_HALF
                            - {2'b00, quo_fin[dbcd_pkg::QUO_W-2:0]};
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            first_reg <= first_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        mag_reg    <= mag_next;
        zero_reg   <= zero_next;
        health_reg <= health_next;
    end

    assign done   = done_reg;
    assign health = health_reg;

endmodule
`default_nettype wire

// ===== rtl/deadband_change_detector.sv =====
// top level of the deadband change detector with high and low alarm limits
`default_nettype none
// Report-by-exception filter for signed Q16.16 sensor samples. Each request
// gives exactly one result. A sample flagged invalid gives "no change". A
// valid sample at or above the enabled high limit (checked first) or at or
// below the enabled low limit gives a health event with a health index
// 0.5 - overshoot/|limit| in units of 1/65536, clamped to 0..0.5. Otherwise
// the first sample is a measurement event and later ones are events when
// |sample - last| reaches the dead band (zero dead band reports every
// sample). Every event stores the sample as the new last value. A request
// passes the classify and decide states and, for a health event, the
// divider before its result is registered in the output register. A serial
// restoring divider makes one trial subtraction per cycle for 16 quotient
// bits after one range check, which alone settles a health event whose
// overshoot reaches the limit magnitude or whose limit is zero. A request
// holds the block until the output register is free to take its result;
// one request is in flight at a time, and a finished result waits in the
// output register while the next request is taken. The user must write
// configuration only while the block is idle; the block does not enforce it.
module deadband_change_detector (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [dbcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dbcd_pkg::DATA_W-1:0]         cfg_wr_data,
    // request channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [dbcd_pkg::DATA_W-1:0]  s_sample,
    input  wire logic                                s_sample_valid,
    // result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [dbcd_pkg::KIND_W-1:0]              m_event_kind,
    output logic                                     m_above_high,
    output logic signed [dbcd_pkg::DATA_W-1:0]       m_sample_echo,
    output logic signed [dbcd_pkg::CHANGE_W-1:0]     m_change,
    output logic [dbcd_pkg::HEALTH_W-1:0]            m_health,
    output logic [dbcd_pkg::SEV_W-1:0]               m_severity_out
);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLASS  = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    dbcd_pkg::cfg_t cfg;

    logic [2:0] state_reg, state_next;

    // request capture
    logic signed [dbcd_pkg::DATA_W-1:0]   samp_reg;
    logic                                 sval_reg;

    // classification results
    logic                                 hi_hit_reg, lo_hit_reg;
    logic signed [dbcd_pkg::CHANGE_W-1:0] diff_reg;
    logic [dbcd_pkg::DATA_W-1:0]          past_reg;
    logic signed [dbcd_pkg::DATA_W-1:0]   lim_reg;

    // decision
    logic [dbcd_pkg::KIND_W-1:0]          kind_reg, kind_next;
    logic signed [dbcd_pkg::CHANGE_W-1:0] chg_reg, chg_next;

    // stored last reported value
    logic signed [dbcd_pkg::DATA_W-1:0]   last_reg;
    logic                                 have_last_reg;

    // output register
    logic                                 m_valid_reg;
    logic [dbcd_pkg::KIND_W-1:0]          o_kind_reg;
    logic                                 o_above_reg;
    logic signed [dbcd_pkg::DATA_W-1:0]   o_samp_reg;
    logic signed [dbcd_pkg::CHANGE_W-1:0] o_chg_reg;
    logic [dbcd_pkg::HEALTH_W-1:0]        o_health_reg;
    logic [dbcd_pkg::SEV_W-1:0]           o_sev_reg;

    logic                                 hi_hit, lo_hit;
    logic signed [dbcd_pkg::CHANGE_W-1:0] diff_c;
    logic signed [dbcd_pkg::CHANGE_W-1:0] past_hi, past_lo;
    logic [dbcd_pkg::CHANGE_W-1:0]        abs_diff;
    logic                                 in_band;
    logic                                 div_start, div_done;
    logic [dbcd_pkg::HEALTH_W-1:0]        div_health;
    logic                                 accept_in, out_free;

    assign accept_in = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);

    dbcd_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // limit checks, overshoot and change against the stored value
    always_comb begin
        hi_hit  = cfg.high_en && (samp_reg >= cfg.high_lim);
        lo_hit  = cfg.low_en && (samp_reg <= cfg.low_lim);
        diff_c  = have_last_reg ? ($signed({samp_reg[dbcd_pkg::DATA_W-1], samp_reg})
                                 - $signed({last_reg[dbcd_pkg::DATA_W-1], last_reg}))
                                : '0;
        past_hi = $signed({samp_reg[dbcd_pkg::DATA_W-1], samp_reg})
                - $signed({cfg.high_lim[dbcd_pkg::DATA_W-1], cfg.high_lim});
        past_lo = $signed({cfg.low_lim[dbcd_pkg::DATA_W-1], cfg.low_lim})
                - $signed({samp_reg[dbcd_pkg::DATA_W-1], samp_reg});
    end

    // dead band test and event decision
    always_comb begin
        abs_diff  = diff_reg[dbcd_pkg::CHANGE_W-1] ? (~diff_reg + 1'b1) : diff_reg;
        in_band   = (cfg.dband != '0) && (abs_diff < {2'b00, cfg.dband});
        kind_next = dbcd_pkg::KIND_NONE;
        chg_next  = '0;
        if (sval_reg) begin
            if (hi_hit_reg || lo_hit_reg) begin
                kind_next = dbcd_pkg::KIND_HEALTH;
                chg_next  = diff_reg;
            end else if (!have_last_reg) begin
                kind_next = dbcd_pkg::KIND_MEAS;
            end else begin
                chg_next  = diff_reg;
                kind_next = in_band ? dbcd_pkg::KIND_NONE : dbcd_pkg::KIND_MEAS;
            end
        end
    end

    assign div_start = (state_reg == ST_DECIDE) && (kind_next == dbcd_pkg::KIND_HEALTH);

    dbcd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .past    (past_reg),
        .limit   (lim_reg),
        .done    (div_done),
        .health  (div_health)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept_in) state_next = ST_CLASS;
            end
            ST_CLASS: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = div_start ? ST_DIV : ST_FIN;
            end
            ST_DIV: begin
                if (div_done) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            have_last_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
                if (kind_reg != dbcd_pkg::KIND_NONE) have_last_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            samp_reg <= s_sample;
            sval_reg <= s_sample_valid;
        end
        if (state_reg == ST_CLASS) begin
            hi_hit_reg <= hi_hit;
            lo_hit_reg <= lo_hit;
            diff_reg   <= diff_c;
            // high limit wins when both are hit
            past_reg   <= hi_hit ? past_hi[dbcd_pkg::DATA_W-1:0]
                                 : past_lo[dbcd_pkg::DATA_W-1:0];
            lim_reg    <= hi_hit ? cfg.high_lim : cfg.low_lim;
        end
        if (state_reg == ST_DECIDE) begin
            kind_reg <= kind_next;
            chg_reg  <= chg_next;
        end
        if (state_reg == ST_FIN && out_free) begin
            if (kind_reg != dbcd_pkg::KIND_NONE) last_reg <= samp_reg;
            o_kind_reg   <= kind_reg;
            o_above_reg  <= (kind_reg == dbcd_pkg::KIND_HEALTH) && hi_hit_reg;
            o_samp_reg   <= samp_reg;
            o_chg_reg    <= chg_reg;
            o_health_reg <= (kind_reg == dbcd_pkg::KIND_HEALTH) ? div_health
                                                                : dbcd_pkg::HEALTH_FULL;
            o_sev_reg    <= cfg.severity;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_kind   = o_kind_reg;
    assign m_above_high   = o_above_reg;
    assign m_sample_echo  = o_samp_reg;
    assign m_change       = o_chg_reg;
    assign m_health       = o_health_reg;
    assign m_severity_out = o_sev_reg;

endmodule
`default_nettype wire

// ===== rtl/dbcd_checker.sv =====
// port-level checker for the deadband change detector, bound to the top level
`default_nettype none
module dbcd_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    input  wire logic                                s_ready,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic [dbcd_pkg::KIND_W-1:0]         m_event_kind,
    input  wire logic                                m_above_high,
    input  wire logic [dbcd_pkg::HEALTH_W-1:0]       m_health
);

    // a stalled result keeps its fields
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind) && $stable(m_health))
        else $error("result changed while stalled");

    // only health events carry an index below full scale or the high flag
    a_non_health: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != dbcd_pkg::KIND_HEALTH |->
            m_health == dbcd_pkg::HEALTH_FULL && !m_above_high)
        else $error("non-health result with health fields set");

    // health index of a health event is within 0..0.5
    a_health_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == dbcd_pkg::KIND_HEALTH |->
            m_health <= dbcd_pkg::HEALTH_HALF)
        else $error("health index above one half");

    // a request accepted leaves the block busy for the next cycle
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in flight");

endmodule

bind deadband_change_detector dbcd_checker u_dbcd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_event_kind (m_event_kind),
    .m_above_high (m_above_high),
    .m_health     (m_health)
);
`default_nettype wire

// ===== bench/dbcd_report_check.sv =====
// result checker for the deadband change detector: predicts every request and compares results
module dbcd_report_check (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [dbcd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [dbcd_pkg::DATA_W-1:0]             cfg_wr_data,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic signed [dbcd_pkg::DATA_W-1:0]      s_sample,
    input  logic                                    s_sample_valid,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic [dbcd_pkg::KIND_W-1:0]             m_event_kind,
    input  logic                                    m_above_high,
    input  logic signed [dbcd_pkg::DATA_W-1:0]      m_sample_echo,
    input  logic signed [dbcd_pkg::CHANGE_W-1:0]    m_change,
    input  logic [dbcd_pkg::HEALTH_W-1:0]           m_health,
    input  logic [dbcd_pkg::SEV_W-1:0]              m_severity_out,
    output int                                      mismatches,
    output int                                      reports_seen,
    output int                                      reports_owed
);
    import dbcd_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic                       above;
        logic signed [DATA_W-1:0]   echo;
        logic signed [CHANGE_W-1:0] change;
        logic [HEALTH_W-1:0]        health;
        logic [SEV_W-1:0]           severity;
    } event_report_t;

    cfg_t                     settings;
    logic signed [DATA_W-1:0] stored_sample;
    logic                     have_last;
    event_report_t            reports_due[$];

    // 0.5 - past/|limit| in units of 1/65536, floored quotient, clamped at zero
    function automatic logic [HEALTH_W-1:0] health_code(input longint past,
                                                        input longint limit);
        longint mag;
        longint quot;
        logic [HEALTH_W-1:0] idx;
        mag = (limit < 0) ? -limit : limit;
        if (mag == 0) return HEALTH_HALF;
        quot = (past <<< 16) / mag;
        if (quot >= longint'(HEALTH_HALF)) return '0;
        idx = HEALTH_HALF - quot[HEALTH_W-1:0];
        return idx;
    endfunction

    function automatic event_report_t detect_event(input logic signed [DATA_W-1:0] smp,
                                                   input logic good);
        event_report_t rep;
        longint s;
        longint diff;
        longint hi;
        longint lo;
        longint band;
        longint mag;
        s    = smp;
        hi   = $signed(settings.high_lim);
        lo   = $signed(settings.low_lim);
        band = longint'(settings.dband);
        rep.kind     = KIND_NONE;
        rep.above    = 1'b0;
        rep.echo     = smp;
        rep.change   = '0;
        rep.health   = HEALTH_FULL;
        rep.severity = settings.severity;
        if (good) begin
            diff = have_last ? s - longint'(stored_sample) : 0;
            if (settings.high_en && s >= hi) begin
                rep.kind   = KIND_HEALTH;
                rep.above  = 1'b1;
                rep.health = health_code(s - hi, hi);
                rep.change = diff[CHANGE_W-1:0];
            end else if (settings.low_en && s <= lo) begin
                rep.kind   = KIND_HEALTH;
                rep.health = health_code(lo - s, lo);
                rep.change = diff[CHANGE_W-1:0];
            end else if (!have_last) begin
                rep.kind = KIND_MEAS;
            end else begin
                mag = (diff < 0) ? -diff : diff;
                rep.change = diff[CHANGE_W-1:0];
                rep.kind   = (band > 0 && mag < band) ? KIND_NONE : KIND_MEAS;
            end
            if (rep.kind != KIND_NONE) begin
                stored_sample = smp;
                have_last     = 1'b1;
            end
        end
        return rep;
    endfunction

    task automatic compare_field(input string label, input logic [CHANGE_W-1:0] want,
                                 input logic [CHANGE_W-1:0] got, inout bit bad);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            bad = 1'b1;
        end
    endtask

    always @(posedge aclk) begin : watch
        event_report_t want;
        bit bad;
        if (!aresetn) begin
            settings      = '0;
            stored_sample = '0;
            have_last     = 1'b0;
            reports_due.delete();
            mismatches   <= 0;
            reports_seen <= 0;
            reports_owed <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_HIGH_EN:  settings.high_en  = cfg_wr_data[0];
                    REG_HIGH_LIM: settings.high_lim = cfg_wr_data;
                    REG_LOW_EN:   settings.low_en   = cfg_wr_data[0];
                    REG_LOW_LIM:  settings.low_lim  = cfg_wr_data;
                    REG_DBAND:    settings.dband    = cfg_wr_data[DBAND_W-1:0];
                    REG_SEVERITY: settings.severity = cfg_wr_data[SEV_W-1:0];
                    default: ;
                endcase
            end
            // results before requests: one taken at this edge cannot have its result out yet
            if (m_valid && m_ready) begin
                bad = 1'b0;
                if (reports_due.size() == 0) begin
                    $display("%0t: unrequested result, expected none, actual kind %h sample %h",
                             $time, m_event_kind, m_sample_echo);
                    bad = 1'b1;
                end else begin
                    want = reports_due.pop_front();
                    compare_field("event_kind", CHANGE_W'(want.kind),
                                  CHANGE_W'(m_event_kind), bad);
                    compare_field("above_high", CHANGE_W'(want.above),
                                  CHANGE_W'(m_above_high), bad);
                    compare_field("sample_echo", CHANGE_W'(want.echo),
                                  CHANGE_W'(m_sample_echo), bad);
                    compare_field("change", want.change, m_change, bad);
                    compare_field("health", CHANGE_W'(want.health),
                                  CHANGE_W'(m_health), bad);
                    compare_field("severity_out", CHANGE_W'(want.severity),
                                  CHANGE_W'(m_severity_out), bad);
                end
                if (bad) mismatches <= mismatches + 1;
                reports_seen <= reports_seen + 1;
            end
            if (s_valid && s_ready) reports_due.push_back(detect_event(s_sample, s_sample_valid));
            reports_owed <= reports_due.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// stimulus and verdict for the deadband change detector, with the result checker alongside
module tb_top;
    import dbcd_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int QUIET_LIMIT      = 1000;  // cycles with no handshake at all before giving up
    localparam int HOLD_OFF_CYCLES  = 120;   // long receiver hold-off, well past the block's depth
    localparam int DRAIN_CYCLES     = 40;    // idle time after the last result to catch any extra result
    localparam int RANDOM_PHASES    = 9;
    localparam int ITEMS_PER_PHASE  = 64;

    // register indexes the block does not decode, written to check they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [DATA_W-1:0]            cfg_wr_data;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [DATA_W-1:0]     s_sample;
    logic                         s_sample_valid;
    logic                         m_valid;
    logic                         m_ready;
    logic [KIND_W-1:0]            m_event_kind;
    logic                         m_above_high;
    logic signed [DATA_W-1:0]     m_sample_echo;
    logic signed [CHANGE_W-1:0]   m_change;
    logic [HEALTH_W-1:0]          m_health;
    logic [SEV_W-1:0]             m_severity_out;

    int mismatches;
    int reports_seen;
    int reports_owed;

    // sender bookkeeping
    int                       requests_sent;
    int                       gap_pct;
    logic signed [DATA_W-1:0] hi_lim;
    logic signed [DATA_W-1:0] lo_lim;
    logic [DBAND_W-1:0]       band;
    logic signed [DATA_W-1:0] prev_sample;

    // receiver controls, changed with nonblocking writes so the sink sees them cleanly
    int sink_stall_pct;
    int hold_off_asks;

    int quiet_cycles;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    deadband_change_detector uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_sample_valid (s_sample_valid),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_above_high   (m_above_high),
        .m_sample_echo  (m_sample_echo),
        .m_change       (m_change),
        .m_health       (m_health),
        .m_severity_out (m_severity_out)
    );

    dbcd_report_check u_report_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_sample_valid (s_sample_valid),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_above_high   (m_above_high),
        .m_sample_echo  (m_sample_echo),
        .m_change       (m_change),
        .m_health       (m_health),
        .m_severity_out (m_severity_out),
        .mismatches     (mismatches),
        .reports_seen   (reports_seen),
        .reports_owed   (reports_owed)
    );

    // one register write per clock, enable left high for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    // hold the sender until every request has its result, then rewrite all registers;
    // unused upper data bits carry noise, the block must drop them
    task automatic apply_settings(input logic he, input logic signed [DATA_W-1:0] hl,
                                  input logic le, input logic signed [DATA_W-1:0] ll,
                                  input logic [DBAND_W-1:0] db, input logic [SEV_W-1:0] sev,
                                  input bit poke_spare);
        logic [DATA_W-1:0] noise;
        s_valid <= 1'b0;
        while (reports_seen != requests_sent) @(posedge aclk);
        noise = $urandom();
        write_reg(REG_HIGH_EN, {noise[DATA_W-1:1], he});
        write_reg(REG_HIGH_LIM, hl);
        noise = $urandom();
        write_reg(REG_LOW_EN, {noise[DATA_W-1:1], le});
        write_reg(REG_LOW_LIM, ll);
        noise = $urandom();
        write_reg(REG_DBAND, {noise[DATA_W-1], db});
        noise = $urandom();
        write_reg(REG_SEVERITY, {noise[DATA_W-1:SEV_W], sev});
        if (poke_spare) begin
            write_reg(REG_SPARE_A, $urandom());
            write_reg(REG_SPARE_B, $urandom());
        end
        cfg_wr_en <= 1'b0;
        hi_lim = hl;
        lo_lim = ll;
        band   = db;
    endtask

    // present one request and hold it until the block takes it
    task automatic offer(input logic signed [DATA_W-1:0] smp, input logic ok);
        s_valid        <= 1'b1;
        s_sample       <= smp;
        s_sample_valid <= ok;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    // random idle burst on the request side
    task automatic sender_gap();
        if ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // limits: extremes, zero, anything, or a modest Q16.16 value of either sign
    function automatic logic signed [DATA_W-1:0] random_limit();
        int unsigned whole;
        int unsigned frac;
        logic signed [DATA_W-1:0] lim;
        case ($urandom_range(0, 7))
            0: lim = 32'sh7FFF_FFFF;
            1: lim = 32'sh8000_0000;
            2: lim = '0;
            3: lim = $urandom();
            default: begin
                whole = $urandom_range(0, 2000);
                frac  = $urandom_range(0, 65535);
                lim   = {whole[15:0], frac[15:0]};
                if ($urandom_range(0, 1)) lim = -lim;
            end
        endcase
        return lim;
    endfunction

    task automatic pick_settings(input int ph);
        logic                     he;
        logic                     le;
        logic signed [DATA_W-1:0] hl;
        logic signed [DATA_W-1:0] ll;
        logic signed [DATA_W-1:0] swap;
        logic [DBAND_W-1:0]       db;
        logic [31:0]              sev;
        he = ($urandom_range(0, 9) < 7);
        le = ($urandom_range(0, 9) < 7);
        hl = random_limit();
        ll = random_limit();
        // mostly keep a window between the limits so the dead band path gets used
        if (hl < ll && $urandom_range(0, 2) != 0) begin
            swap = hl;
            hl   = ll;
            ll   = swap;
        end
        case ($urandom_range(0, 4))
            0: db = '0;
            1: db = '1;
            2: db = DBAND_W'($urandom());
            default: db = DBAND_W'($urandom_range(1, 50 * 65536));
        endcase
        case ($urandom_range(0, 3))
            0: sev = 0;
            1: sev = 255;
            default: sev = $urandom_range(0, 255);
        endcase
        apply_settings(he, hl, le, ll, db, sev[SEV_W-1:0], ph[0]);
    endtask

    // samples clustered around the last value and both limits, plus noise and read failures
    task automatic next_sample(output logic signed [DATA_W-1:0] smp, output logic ok);
        int unsigned pick;
        longint span;
        longint off;
        longint reach;
        pick = $urandom_range(0, 99);
        ok   = 1'b1;
        if (pick < 10) begin
            ok  = 1'b0;
            smp = $urandom();
        end else if (pick < 15) begin
            // exactly one dead band away
            off = longint'(band);
            if ($urandom_range(0, 1)) off = -off;
            smp = 32'(longint'(prev_sample) + off);
        end else if (pick < 40) begin
            span = (band == 0) ? 64'd8192 : 2 * longint'(band);
            if (span > 64'h1000_0000) span = 64'h1000_0000;
            off = longint'($urandom_range(0, 32'(span))) - span / 2;
            smp = 32'(longint'(prev_sample) + off);
        end else if (pick < 60) begin
            // from just under the high limit up to its magnitude past it
            reach = longint'(hi_lim);
            if (reach < 0) reach = -reach;
            if (reach > 64'h4000_0000) reach = 64'h4000_0000;
            smp = 32'(longint'(hi_lim) - 2 + longint'($urandom_range(0, 32'(reach))));
        end else if (pick < 80) begin
            reach = longint'(lo_lim);
            if (reach < 0) reach = -reach;
            if (reach > 64'h4000_0000) reach = 64'h4000_0000;
            smp = 32'(longint'(lo_lim) + 2 - longint'($urandom_range(0, 32'(reach))));
        end else begin
            smp = $urandom();
        end
        if (ok) prev_sample = smp;
    endtask

    // result side: random stalls, and one long hold-off on request from the stimulus
    initial begin : result_sink
        int hold_offs_done;
        hold_offs_done = 0;
        forever begin
            if (hold_off_asks != hold_offs_done) begin
                // long hold-off so the block fills and stops taking requests
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_offs_done++;
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 99) < sink_stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // watchdog: a run that stops moving is a failure
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("deadband_change_detector test failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic signed [DATA_W-1:0] smp;
        logic                     ok;
        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= REG_HIGH_EN;
        cfg_wr_data    <= '0;
        s_valid        <= 1'b0;
        s_sample       <= '0;
        s_sample_valid <= 1'b0;
        requests_sent  = 0;
        prev_sample    = '0;
        hi_lim         = '0;
        lo_lim         = '0;
        band           = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, with moderate idling on both sides
        gap_pct = 30;
        sink_stall_pct <= 30;

        // no limits, zero dead band
        apply_settings(1'b0, '0, 1'b0, '0, '0, 8'h00, 1'b0);
        offer(32'sh1234_5678, 1'b0);   // read failure before anything is stored
        sender_gap();
        offer(32'sh7FFF_FFFF, 1'b1);   // first good sample always reports
        sender_gap();
        offer(32'sh8000_0000, 1'b1);   // widest possible negative change
        sender_gap();
        offer(32'sh8000_0000, 1'b1);   // no change at all still reports with zero dead band
        sender_gap();
        offer(32'shFFFF_FFFF, 1'b0);   // read failure with every sample bit set
        sender_gap();

        // window of -100.0 .. 100.0, dead band 5.0
        apply_settings(1'b1, 32'sh0064_0000, 1'b1, 32'shFF9C_0000, 31'h0005_0000, 8'hA5, 1'b0);
        offer(32'sh0000_0000, 1'b1);   // large jump inside the window
        sender_gap();
        offer(32'sh0001_0000, 1'b1);   // inside the dead band, nothing stored
        sender_gap();
        offer(32'sh0005_0000, 1'b1);   // exactly one dead band away
        sender_gap();
        offer(32'sh0064_0000, 1'b1);   // sitting on the high limit
        sender_gap();
        offer(32'sh0096_0000, 1'b1);   // half the limit past it, index clamps to zero
        sender_gap();
        offer(32'sh0065_0000, 1'b1);   // just past the high limit
        sender_gap();
        offer(32'shFF9C_0000, 1'b1);   // sitting on the low limit
        sender_gap();
        offer(32'shFF7E_0000, 1'b1);   // well below the low limit
        sender_gap();
        offer(32'sh0002_0000, 1'b0);   // read failure keeps the stored value
        sender_gap();
        offer(32'sh7FFF_FFFF, 1'b1);   // far past the high limit
        sender_gap();

        // crossed limits: both hit, high takes precedence; widest dead band
        apply_settings(1'b1, 32'shFFF6_0000, 1'b1, 32'sh000A_0000, 31'h7FFF_FFFF, 8'hFF, 1'b0);
        offer(32'sh0000_0000, 1'b1);
        sender_gap();
        offer(32'shFFF7_0000, 1'b1);
        sender_gap();

        // high limit of zero gives the half-scale index
        apply_settings(1'b1, '0, 1'b0, 32'sh8000_0000, 31'h7FFF_FFFF, 8'h00, 1'b0);
        offer(32'sh0000_0000, 1'b1);
        sender_gap();
        offer(32'shFFFF_0000, 1'b1);   // under the dead band
        sender_gap();
        offer(32'sh8000_0000, 1'b1);   // change of -2^31 reaches the widest dead band
        sender_gap();

        // limits at the extremes of the range, smallest dead band, spare indexes poked
        apply_settings(1'b1, 32'sh7FFF_FFFF, 1'b1, 32'sh8000_0000, 31'd1, 8'h5A, 1'b1);
        offer(32'sh8000_0000, 1'b1);
        sender_gap();
        offer(32'sh7FFF_FFFF, 1'b1);
        sender_gap();
        offer(32'sh7FFF_FFFE, 1'b1);   // one lsb of change meets a one lsb dead band
        sender_gap();

        // random part, one fresh set of registers per phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick_settings(ph);
            // idling varies by phase: some, none, heavy; the last phase runs flat out
            case (ph % 3)
                0: gap_pct = 25;
                1: gap_pct = 0;
                default: gap_pct = 50;
            endcase
            if (ph == RANDOM_PHASES - 1) gap_pct = 0;
            sink_stall_pct <= gap_pct;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long receiver hold-off while requests keep coming
                if (ph == 1 && n == 8) hold_off_asks <= hold_off_asks + 1;
                next_sample(smp, ok);
                offer(smp, ok);
                sender_gap();
            end
        end

        // wait for every result, then give the block time to show anything extra
        s_valid <= 1'b0;
        while (reports_seen != requests_sent) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && reports_owed == 0) begin
            $display("deadband_change_detector test passed");
        end else begin
            $display("deadband_change_detector test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dbcd_pkg.sv
rtl/dbcd_cfg.sv
rtl/dbcd_div.sv
rtl/deadband_change_detector.sv
rtl/dbcd_checker.sv
bench/dbcd_report_check.sv
bench/tb_top.sv
